/* hw/rtl/sle_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sle_pkg: shared types and constants for the sprite line evaluator
// Opcodes, register indexes, field widths and the slot record layout.
// ----------------------------------------------------------------------------
package sle_pkg;

   // default configuration
   localparam int SLOTS_PER_LINE_DEF = 8;
   localparam int ENTRY_COUNT_DEF    = 64;

   // attribute memory geometry: four bytes per entry
   localparam int ATTR_ROWS  = 64;
   localparam int ROW_W      = 6;
   localparam int LANES      = 4;
   localparam int BYTE_W     = 8;
   localparam int ADDR_W     = 8;

   // field widths
   localparam int TOP_W        = 9;
   localparam int PATTERN_W    = 13;
   localparam int SLOT_INDEX_W = 3;
   localparam int PALETTE_W    = 3;

   // csr port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TALL_SPRITES = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TABLE_HIGH   = 1'd1;

   // request opcodes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_EVAL  = 1'b1;

   // byte lanes within an entry
   localparam int LANE_Y    = 0;
   localparam int LANE_TILE = 1;
   localparam int LANE_ATTR = 2;
   localparam int LANE_X    = 3;

   // attribute bits
   localparam int ATTR_BEHIND_BIT = 5;
   localparam int ATTR_FLIPX_BIT  = 6;
   localparam int ATTR_FLIPY_BIT  = 7;

   // empty slot marker
   localparam logic [TOP_W-1:0] EMPTY_TOP = 9'd255;
   localparam logic [PALETTE_W-1:0] PALETTE_BASE = 3'd4;

   // one attribute entry as read from the four lanes
   typedef struct packed {
      logic [BYTE_W-1:0] y;
      logic [BYTE_W-1:0] tile;
      logic [BYTE_W-1:0] attr;
      logic [BYTE_W-1:0] x;
   } attr_row_type;

   // what a slot holds once a sprite lands in it
   typedef struct packed {
      logic [TOP_W-1:0]     top;
      logic [BYTE_W-1:0]    left;
      logic [PATTERN_W-1:0] pattern_addr;
      logic [1:0]           palette_lo;
      logic                 behind;
      logic                 mirror_x;
      logic                 mirror_y;
   } slot_rec_type;

   localparam int SLOT_REC_W = $bits(slot_rec_type);

   // verdict of the compare unit for one entry
   typedef struct packed {
      logic         hit;
      slot_rec_type rec;
   } hit_type;

   // mode bits handed to the compare unit
   typedef struct packed {
      logic tall_sprites;
      logic sprite_table_high;
   } mode_type;

endpackage
`default_nettype wire

/* hw/rtl/sle_ifs.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sle_ifs: channel interfaces of the sprite line evaluator
// Request, response and csr channels, each with valid/ready and payload.
// ----------------------------------------------------------------------------

// request channel: attribute byte write or line evaluation
interface sle_req_if;
   logic                         valid;
   logic                         ready;
   logic                         op;
   logic [sle_pkg::ADDR_W-1:0]   attr_addr;
   logic [sle_pkg::BYTE_W-1:0]   attr_data;
   logic [sle_pkg::BYTE_W-1:0]   line_number;

   modport source (output valid, op, attr_addr, attr_data, line_number, input ready);
   modport sink   (input valid, op, attr_addr, attr_data, line_number, output ready);
endinterface

// response channel: one word per slot
interface sle_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [sle_pkg::SLOT_INDEX_W-1:0]   slot_index;
   logic                               slot_valid;
   logic [sle_pkg::TOP_W-1:0]          sprite_top;
   logic [sle_pkg::BYTE_W-1:0]         sprite_left;
   logic [sle_pkg::PATTERN_W-1:0]      pattern_addr;
   logic [sle_pkg::PALETTE_W-1:0]      palette_number;
   logic                               in_front;
   logic                               mirror_x;
   logic                               mirror_y;
   logic                               overflow;
   logic                               entry0_on_line;
   logic                               last;

   modport source (output valid, slot_index, slot_valid, sprite_top, sprite_left,
                   pattern_addr, palette_number, in_front, mirror_x, mirror_y,
                   overflow, entry0_on_line, last, input ready);
   modport sink   (input valid, slot_index, slot_valid, sprite_top, sprite_left,
                   pattern_addr, palette_number, in_front, mirror_x, mirror_y,
                   overflow, entry0_on_line, last, output ready);
endinterface

// csr write channel
interface sle_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [sle_pkg::CSR_INDEX_W-1:0]      index;
   logic [sle_pkg::CSR_DATA_W-1:0]       data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/sprite_line_evaluator_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sprite_line_evaluator_top: per-line sprite evaluation
// Holds 256 bytes of sprite attributes and scans them for one line at a time.
//
//   channel  dir   handshake      payload
//   req      in    valid/ready    op, attr_addr, attr_data, line_number
//   rsp      out   valid/ready    one slot word, last on the final slot
//   csr      in    valid/ready    index, data (tall_sprites, sprite_table_high)
//
// an evaluation scans the entries, one entry per cycle through the single compare
// unit and the four lane RAM read ports, then reads back the slot RAM slot by slot
// reset clears the mode bits and the per-byte valid flags, so every byte reads
// as zero until written; no clearing pass is needed
// req is ready only between evaluations; rsp stalls hold the slot read-back,
// and csr is always ready
// ----------------------------------------------------------------------------
module sprite_line_evaluator_top #(
   parameter int SLOTS_PER_LINE = sle_pkg::SLOTS_PER_LINE_DEF,
   parameter int ENTRY_COUNT    = sle_pkg::ENTRY_COUNT_DEF
) (
   input wire logic     clock,
   input wire logic     reset,
   sle_req_if.sink      req,
   sle_rsp_if.source    rsp,
   sle_csr_if.sink      csr
);

   localparam int SLOT_AW = (SLOTS_PER_LINE > 1) ? $clog2(SLOTS_PER_LINE) : 1;
   localparam int USED_W  = $clog2(SLOTS_PER_LINE + 1);
   localparam int CNT_W   = $clog2(ENTRY_COUNT + 1);
   localparam int ROW_W   = sle_pkg::ROW_W;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_RD    = 2'd2;
   localparam logic [1:0] ST_LD    = 2'd3;

   // output register layout
   typedef struct packed {
      logic [sle_pkg::SLOT_INDEX_W-1:0] slot_index;
      logic                             slot_valid;
      sle_pkg::slot_rec_type            rec;
      logic                             overflow;
      logic                             entry0;
      logic                             last;
   } rsp_word_type;

   logic [1:0]                  state_ff, state_in;
   sle_pkg::mode_type           mode_ff, mode_in;
   logic [sle_pkg::BYTE_W-1:0]  line_ff, line_in;
   logic [CNT_W-1:0]            scan_cnt_ff, scan_cnt_in;
   logic                        proc_valid_ff, proc_valid_in;
   logic [ROW_W-1:0]            proc_row_ff, proc_row_in;
   logic [sle_pkg::LANES-1:0]   lane_valid_ff, lane_valid_in;
   logic [USED_W-1:0]           used_ff, used_in;
   logic                        overflow_ff, overflow_in;
   logic                        entry0_ff, entry0_in;
   logic [SLOT_AW-1:0]          drain_ff, drain_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   rsp_word_type                rsp_word_ff, rsp_word_in;
   logic [(1 << sle_pkg::ADDR_W)-1:0] byte_valid_ff, byte_valid_in;

   logic                        req_fire;
   logic                        byte_write;
   logic                        scan_issue;
   logic [ROW_W-1:0]            rd_row;
   logic [sle_pkg::BYTE_W-1:0]  lane_data [sle_pkg::LANES];
   sle_pkg::attr_row_type       row;
   sle_pkg::hit_type            hit;
   logic                        slots_full;
   logic                        slot_wr_en;
   logic                        drain_last;
   logic                        drain_used;
   sle_pkg::slot_rec_type       slot_rd_rec;
   logic [sle_pkg::SLOT_REC_W-1:0] slot_rd_data;

   assign req_fire   = req.valid && req.ready;
   assign byte_write = req_fire && (req.op == sle_pkg::OP_WRITE);
   assign req.ready  = (state_ff == ST_IDLE);
   assign csr.ready  = 1'b1;

   // ---------------------------------------------------------------
   // attribute memory: one RAM per byte lane, one row per entry
   // ---------------------------------------------------------------
   assign scan_issue = (state_ff == ST_SCAN) && (scan_cnt_ff < CNT_W'(ENTRY_COUNT));
   assign rd_row     = ROW_W'(scan_cnt_ff);

   for (genvar lane = 0; lane < sle_pkg::LANES; lane++) begin : g_lane
      sle_ram #(
         .WIDTH (sle_pkg::BYTE_W),
         .DEPTH (sle_pkg::ATTR_ROWS)
      ) u_lane_ram (
         .clock   (clock),
         .wr_en   (byte_write && (req.attr_addr[1:0] == 2'(lane))),
         .wr_addr (req.attr_addr[sle_pkg::ADDR_W-1:2]),
         .wr_data (req.attr_data),
         .rd_addr (rd_row),
         .rd_data (lane_data[lane])
      );

      // never-written bytes read as zero
      assign lane_valid_in[lane] = byte_valid_ff[{rd_row, 2'(lane)}];
   end

   assign row.y    = lane_data[sle_pkg::LANE_Y]    & {sle_pkg::BYTE_W{lane_valid_ff[sle_pkg::LANE_Y]}};
   assign row.tile = lane_data[sle_pkg::LANE_TILE] & {sle_pkg::BYTE_W{lane_valid_ff[sle_pkg::LANE_TILE]}};
   assign row.attr = lane_data[sle_pkg::LANE_ATTR] & {sle_pkg::BYTE_W{lane_valid_ff[sle_pkg::LANE_ATTR]}};
   assign row.x    = lane_data[sle_pkg::LANE_X]    & {sle_pkg::BYTE_W{lane_valid_ff[sle_pkg::LANE_X]}};

   // byte valid flags
   always_comb begin
      byte_valid_in = byte_valid_ff;
      if (byte_write) begin
         byte_valid_in[req.attr_addr] = 1'b1;
      end
   end

   // ---------------------------------------------------------------
   // shared compare unit
   // ---------------------------------------------------------------
   sle_hit_unit u_hit (
      .row    (row),
      .line   (line_ff),
      .mode   (mode_ff),
      .result (hit)
   );

   // ---------------------------------------------------------------
   // slot store
   // ---------------------------------------------------------------
   assign slots_full = (used_ff == USED_W'(SLOTS_PER_LINE));
   assign slot_wr_en = (state_ff == ST_SCAN) && proc_valid_ff && hit.hit && !slots_full;

   sle_ram #(
      .WIDTH (sle_pkg::SLOT_REC_W),
      .DEPTH (SLOTS_PER_LINE)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_wr_en),
      .wr_addr (used_ff[SLOT_AW-1:0]),
      .wr_data (hit.rec),
      .rd_addr (drain_ff),
      .rd_data (slot_rd_data)
   );

   assign slot_rd_rec = sle_pkg::slot_rec_type'(slot_rd_data);
   assign drain_last  = (drain_ff == SLOT_AW'(SLOTS_PER_LINE - 1));
   assign drain_used  = (USED_W'(drain_ff) < used_ff);

   // ---------------------------------------------------------------
   // mode registers
   // ---------------------------------------------------------------
   always_comb begin
      mode_in = mode_ff;
      if (csr.valid && csr.ready) begin
         unique case (csr.index)
            sle_pkg::CSR_TALL_SPRITES: mode_in.tall_sprites      = csr.data[0];
            sle_pkg::CSR_TABLE_HIGH:   mode_in.sprite_table_high = csr.data[0];
         endcase
      end
   end

   // ---------------------------------------------------------------
   // sequencer: scan entries, then read slots back one by one
   // ---------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      line_in       = line_ff;
      scan_cnt_in   = scan_cnt_ff;
      proc_valid_in = scan_issue;
      proc_row_in   = rd_row;
      used_in       = used_ff;
      overflow_in   = overflow_ff;
      entry0_in     = entry0_ff;
      drain_in      = drain_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_word_in   = rsp_word_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req.op == sle_pkg::OP_EVAL)) begin
               state_in    = ST_SCAN;
               line_in     = req.line_number;
               scan_cnt_in = '0;
               used_in     = '0;
               overflow_in = 1'b0;
               entry0_in   = 1'b0;
            end
         end
         ST_SCAN: begin
            if (scan_issue) begin
               scan_cnt_in = scan_cnt_ff + CNT_W'(1);
            end
            if (proc_valid_ff) begin
               if (hit.hit && slots_full) begin
                  // a hit with every slot already taken ends the scan
                  overflow_in = 1'b1;
                  state_in    = ST_RD;
                  drain_in    = '0;
               end else begin
                  if (hit.hit) begin
                     used_in = used_ff + USED_W'(1);
                     if (proc_row_ff == '0) begin
                        entry0_in = 1'b1;
                     end
                  end
                  if (proc_row_ff == ROW_W'(ENTRY_COUNT - 1)) begin
                     state_in = ST_RD;
                     drain_in = '0;
                  end
               end
            end
         end
         ST_RD: begin
            // slot RAM address settles this cycle
            state_in = ST_LD;
         end
         ST_LD: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in                = 1'b1;
               rsp_word_in.slot_index      = sle_pkg::SLOT_INDEX_W'(drain_ff);
               rsp_word_in.slot_valid      = drain_used;
               rsp_word_in.overflow        = overflow_ff;
               rsp_word_in.entry0          = entry0_ff;
               rsp_word_in.last            = drain_last;
               if (drain_used) begin
                  rsp_word_in.rec = slot_rd_rec;
               end else begin
                  rsp_word_in.rec     = '0;
                  rsp_word_in.rec.top = sle_pkg::EMPTY_TOP;
               end
               if (drain_last) begin
                  state_in = ST_IDLE;
               end else begin
                  drain_in = drain_ff + SLOT_AW'(1);
                  state_in = ST_RD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         mode_ff       <= '0;
         byte_valid_ff <= '0;
         proc_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         scan_cnt_ff   <= '0;
         used_ff       <= '0;
         overflow_ff   <= 1'b0;
         entry0_ff     <= 1'b0;
         drain_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         mode_ff       <= mode_in;
         byte_valid_ff <= byte_valid_in;
         proc_valid_ff <= proc_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         scan_cnt_ff   <= scan_cnt_in;
         used_ff       <= used_in;
         overflow_ff   <= overflow_in;
         entry0_ff     <= entry0_in;
         drain_ff      <= drain_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      line_ff       <= line_in;
      proc_row_ff   <= proc_row_in;
      lane_valid_ff <= lane_valid_in;
      rsp_word_ff   <= rsp_word_in;
   end

   // response outputs
   assign rsp.valid          = rsp_valid_ff;
   assign rsp.slot_index     = rsp_word_ff.slot_index;
   assign rsp.slot_valid     = rsp_word_ff.slot_valid;
   assign rsp.sprite_top     = rsp_word_ff.rec.top;
   assign rsp.sprite_left    = rsp_word_ff.rec.left;
   assign rsp.pattern_addr   = rsp_word_ff.rec.pattern_addr;
   assign rsp.palette_number = rsp_word_ff.slot_valid
                               ? (sle_pkg::PALETTE_BASE + {1'b0, rsp_word_ff.rec.palette_lo})
                               : '0;
   assign rsp.in_front       = rsp_word_ff.slot_valid && !rsp_word_ff.rec.behind;
   assign rsp.mirror_x       = rsp_word_ff.rec.mirror_x;
   assign rsp.mirror_y       = rsp_word_ff.rec.mirror_y;
   assign rsp.overflow       = rsp_word_ff.overflow;
   assign rsp.entry0_on_line = rsp_word_ff.entry0;
   assign rsp.last           = rsp_word_ff.last;

   // ---------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------
   a_slot_write_room: assert property (@(posedge clock) disable iff (reset)
      slot_wr_en |-> (used_ff < USED_W'(SLOTS_PER_LINE)))
      else $error("slot store written while full");

   a_last_is_final_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.last) |->
         (rsp.slot_index == sle_pkg::SLOT_INDEX_W'(SLOTS_PER_LINE - 1)))
      else $error("last flag on a slot other than the final one");

   a_eval_starts_scan: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready && (req.op == sle_pkg::OP_EVAL)) |=> (state_ff == ST_SCAN))
      else $error("evaluation accepted without starting a scan");

   a_used_monotonic: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SCAN) && $past(state_ff == ST_SCAN)) |-> (used_ff >= $past(used_ff)))
      else $error("slot count went backwards during a scan");

endmodule
`default_nettype wire

/* hw/rtl/sle_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sle_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* hw/rtl/sle_hit_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sle_hit_unit: shared line compare and slot record builder
// Decides whether one attribute entry covers the line and forms its slot record.
// ----------------------------------------------------------------------------
module sle_hit_unit (
   input  wire sle_pkg::attr_row_type          row,
   input  wire logic [sle_pkg::BYTE_W-1:0]     line,
   input  wire sle_pkg::mode_type              mode,
   output sle_pkg::hit_type                    result
);

   logic [sle_pkg::TOP_W-1:0] top;
   logic [sle_pkg::TOP_W:0]   line_off;
   logic                      below_top;
   logic                      in_height;

   // top = y + 1, offset = line - top
   assign top       = {1'b0, row.y} + sle_pkg::TOP_W'(1);
   assign line_off  = {2'b00, line} - {1'b0, top};
   assign below_top = line_off[sle_pkg::TOP_W];

   // height 16 or 8
   assign in_height = mode.tall_sprites ? (line_off[sle_pkg::TOP_W-1:4] == '0)
                                        : (line_off[sle_pkg::TOP_W-1:3] == '0);

   always_comb begin
      result.hit              = !below_top && in_height;
      result.rec.top          = top;
      result.rec.left         = row.x;
      // tall tiles pick their table from tile bit 0
      if (mode.tall_sprites) begin
         result.rec.pattern_addr = {row.tile[0], row.tile[7:1], 5'b00000};
      end else begin
         result.rec.pattern_addr = {mode.sprite_table_high, row.tile, 4'b0000};
      end
      result.rec.palette_lo   = row.attr[1:0];
      result.rec.behind       = row.attr[sle_pkg::ATTR_BEHIND_BIT];
      result.rec.mirror_x     = row.attr[sle_pkg::ATTR_FLIPX_BIT];
      result.rec.mirror_y     = row.attr[sle_pkg::ATTR_FLIPY_BIT];
   end

endmodule
`default_nettype wire

/* verif/sprite_line_evaluator_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_line_evaluator_top_test: self-checking bench for the line evaluator
// Loads sprite attribute bytes and evaluates lines through the req channel.
// A local copy of the attribute memory and mode bits predicts all eight slot
// words of every evaluation, and each returned word is checked field by field.
// A short table of corner cases runs first. Random scenes follow, placing
// sprites around a chosen line, across several mode settings and with random
// gaps on both channels.
// ----------------------------------------------------------------------------
module sprite_line_evaluator_top_test;
   import sle_pkg::*;

   localparam int SLOTS         = SLOTS_PER_LINE_DEF;
   localparam int ENTRIES       = ENTRY_COUNT_DEF;
   localparam int PHASES        = 6;
   localparam int PHASE_ITEMS   = 65;
   localparam int LONG_HOLD     = 400;
   localparam int SETTLE_CYCLES = 16;
   localparam int DRAIN_CYCLES  = 100;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int PRINT_LIMIT   = 200;
   localparam int DIRECTED_ROWS = 21;

   // one slot word as seen on the rsp channel
   typedef struct packed {
      logic [SLOT_INDEX_W-1:0] slot_index;
      logic                    slot_valid;
      logic [TOP_W-1:0]        top;
      logic [BYTE_W-1:0]       left;
      logic [PATTERN_W-1:0]    pattern;
      logic [PALETTE_W-1:0]    palette;
      logic                    in_front;
      logic                    mirror_x;
      logic                    mirror_y;
      logic                    overflow;
      logic                    entry0;
      logic                    last;
   } slot_word_t;

   // one request, with a fixed slot expectation where known is set
   typedef struct packed {
      logic                 op;
      logic [ADDR_W-1:0]    addr;
      logic [BYTE_W-1:0]    data;
      logic [BYTE_W-1:0]    line_no;
      logic                 known;
      logic                 exp_valid;
      logic [TOP_W-1:0]     exp_top;
      logic [PALETTE_W-1:0] exp_palette;
      logic                 exp_front;
      logic                 exp_overflow;
      logic                 exp_entry0;
   } stim_row_t;

   // corner cases; known rows hold while no entry but entry 0 has been written
   localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
      '{OP_EVAL,  8'd0,   8'd0,   8'd0,   1'b1, 1'b0, EMPTY_TOP, 3'd0, 1'b0, 1'b0, 1'b0},
      '{OP_EVAL,  8'd0,   8'd0,   8'd1,   1'b1, 1'b1, 9'd1, PALETTE_BASE, 1'b1, 1'b1, 1'b1},
      '{OP_EVAL,  8'd0,   8'd0,   8'd8,   1'b1, 1'b1, 9'd1, PALETTE_BASE, 1'b1, 1'b1, 1'b1},
      '{OP_EVAL,  8'd0,   8'd0,   8'd9,   1'b1, 1'b0, EMPTY_TOP, 3'd0, 1'b0, 1'b0, 1'b0},
      '{OP_EVAL,  8'd0,   8'd0,   8'd255, 1'b1, 1'b0, EMPTY_TOP, 3'd0, 1'b0, 1'b0, 1'b0},
      '{OP_WRITE, 8'd0,   8'd255, 8'd0,   1'b0, 1'b0, 9'd0, 3'd0, 1'b0, 1'b0, 1'b0},
      '{OP_WRITE, 8'd1,   8'd255, 8'd0,   1'b0, 1'b0, 9'd0, 3'd0, 1'b0, 1'b0, 1'b0},
      '{OP_WRITE, 8'd2,   8'd255, 8'd0,   1'b0, 1'b0, 9'd0, 3'd0, 1'b0, 1'b0, 1'b0},
      '{OP_WRITE, 8'd3,   8'd255, 8'd0,   1'b0, 1'b0, 9'd0, 3'd0, 1'b0, 1'b0, 1'b0},
      // entry 0 now sits at top 256, off every line
      '{OP_EVAL,  8'd0,   8'd0,   8'd255, 1'b1, 1'b0, EMPTY_TOP, 3'd0, 1'b0, 1'b0, 1'b0},
      '{OP_EVAL,  8'd0,   8'd0,   8'd0,   1'b0, 1'b0, 9'd0, 3'd0, 1'b0, 1'b0, 1'b0},
      '{OP_WRITE, 8'd252, 8'd239, 8'd0,   1'b0, 1'b0, 9'd0, 3'd0, 1'b0, 1'b0, 1'b0},
      '{OP_WRITE, 8'd253, 8'd0,   8'd0,   1'b0, 1'b0, 9'd0, 3'd0, 1'b0, 1'b0, 1'b0},
      '{OP_WRITE, 8'd254, 8'd0,   8'd0,   1'b0, 1'b0, 9'd0, 3'd0, 1'b0, 1'b0, 1'b0},
      '{OP_WRITE, 8'd255, 8'd0,   8'd0,   1'b0, 1'b0, 9'd0, 3'd0, 1'b0, 1'b0, 1'b0},
      '{OP_EVAL,  8'd0,   8'd0,   8'd240, 1'b0, 1'b0, 9'd0, 3'd0, 1'b0, 1'b0, 1'b0},
      '{OP_EVAL,  8'd0,   8'd0,   8'd247, 1'b0, 1'b0, 9'd0, 3'd0, 1'b0, 1'b0, 1'b0},
      '{OP_EVAL,  8'd0,   8'd0,   8'd248, 1'b0, 1'b0, 9'd0, 3'd0, 1'b0, 1'b0, 1'b0},
      '{OP_WRITE, 8'd0,   8'd247, 8'd0,   1'b0, 1'b0, 9'd0, 3'd0, 1'b0, 1'b0, 1'b0},
      '{OP_EVAL,  8'd0,   8'd0,   8'd250, 1'b0, 1'b0, 9'd0, 3'd0, 1'b0, 1'b0, 1'b0},
      '{OP_EVAL,  8'd0,   8'd0,   8'd8,   1'b0, 1'b0, 9'd0, 3'd0, 1'b0, 1'b0, 1'b0}
   };

   // mode per random phase: {tall_sprites, sprite_table_high}
   localparam logic [1:0] PHASE_MODES [PHASES] = '{2'b10, 2'b01, 2'b11, 2'b00, 2'b11, 2'b01};

   logic clock = 1'b0;
   logic reset = 1'b1;

   sle_req_if req_ch ();
   sle_rsp_if rsp_ch ();
   sle_csr_if csr_ch ();

   sprite_line_evaluator_top DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   // local copy of attribute memory and mode bits
   logic [BYTE_W-1:0] oam_copy [256];
   logic              tall_mode;
   logic              table_high;

   slot_word_t expected_slots [$];
   int         mismatch_count = 0;
   int         sent_items     = 0;
   int         cycle_count    = 0;
   bit         steady_pace    = 1'b0;
   bit         hold_pending   = 1'b0;

   // clock generation
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // scan the local memory for one line and queue the eight slot words
   function automatic void evaluate_line(input logic [BYTE_W-1:0] line_no);
      slot_word_t        hits [SLOTS];
      slot_word_t        w;
      int                height;
      int                top;
      int                used;
      logic              ovf;
      logic              on_line0;
      logic [BYTE_W-1:0] tile;
      logic [BYTE_W-1:0] attr;
      height   = tall_mode ? 16 : 8;
      used     = 0;
      ovf      = 1'b0;
      on_line0 = 1'b0;
      for (int e = 0; e < ENTRIES && !ovf; e++) begin
         top = int'(oam_copy[e * LANES + LANE_Y]) + 1;
         if (top <= int'(line_no) && int'(line_no) < top + height) begin
            if (used < SLOTS) begin
               tile         = oam_copy[e * LANES + LANE_TILE];
               attr         = oam_copy[e * LANES + LANE_ATTR];
               w            = '0;
               w.slot_valid = 1'b1;
               w.top        = TOP_W'(top);
               w.left       = oam_copy[e * LANES + LANE_X];
               // tall sprites pick their table from tile bit 0
               if (tall_mode) begin
                  w.pattern = {tile[0], tile[7:1], 5'd0};
               end else begin
                  w.pattern = {1'b0, tile, 4'd0} + (table_high ? 13'h1000 : 13'h0000);
               end
               w.palette    = PALETTE_BASE + {1'b0, attr[1:0]};
               w.in_front   = !attr[ATTR_BEHIND_BIT];
               w.mirror_x   = attr[ATTR_FLIPX_BIT];
               w.mirror_y   = attr[ATTR_FLIPY_BIT];
               hits[used]   = w;
               used++;
               if (e == 0) begin
                  on_line0 = 1'b1;
               end
            end else begin
               ovf = 1'b1;
            end
         end
      end
      for (int k = 0; k < SLOTS; k++) begin
         if (k < used) begin
            w = hits[k];
         end else begin
            w     = '0;
            w.top = EMPTY_TOP;
         end
         w.slot_index = SLOT_INDEX_W'(k);
         w.overflow   = ovf;
         w.entry0     = on_line0;
         w.last       = (k == SLOTS - 1);
         expected_slots.push_back(w);
      end
   endfunction

   // offer one request word after a random gap and record what it implies
   task automatic send_request(input stim_row_t r);
      int         gap;
      slot_word_t w;
      gap = steady_pace ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.op          <= r.op;
      req_ch.attr_addr   <= r.addr;
      req_ch.attr_data   <= r.data;
      req_ch.line_number <= r.line_no;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      if (r.op == OP_WRITE) begin
         oam_copy[r.addr] = r.data;
      end else if (r.known) begin
         for (int k = 0; k < SLOTS; k++) begin
            w            = '0;
            w.slot_index = SLOT_INDEX_W'(k);
            w.slot_valid = r.exp_valid;
            w.top        = r.exp_top;
            w.palette    = r.exp_palette;
            w.in_front   = r.exp_front;
            w.overflow   = r.exp_overflow;
            w.entry0     = r.exp_entry0;
            w.last       = (k == SLOTS - 1);
            expected_slots.push_back(w);
         end
      end else begin
         evaluate_line(r.line_no);
      end
      sent_items++;
   endtask

   // register write; caller drops valid after the last one
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data  <= data;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      case (index)
         CSR_TALL_SPRITES: tall_mode = data[0];
         CSR_TABLE_HIGH:   table_high = data[0];
         default: ;
      endcase
   endtask

   // block is idle once every slot word is back and a byte write has settled
   task automatic wait_idle();
      while (expected_slots.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         mismatch_count++;
         if (mismatch_count <= PRINT_LIMIT) begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
         end
      end
   endtask

   // rsp side: random stalls, one long hold on request, field checks
   initial begin : slot_checker
      int         stall;
      slot_word_t want;
      slot_word_t got;
      rsp_ch.ready <= 1'b0;
      wait (reset == 1'b0);
      forever begin
         if (hold_pending) begin
            hold_pending = 1'b0;
            stall        = LONG_HOLD;
         end else begin
            stall = steady_pace ? 0 : $urandom_range(0, 11);
         end
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (rsp_ch.valid !== 1'b1);
         got.slot_index = rsp_ch.slot_index;
         got.slot_valid = rsp_ch.slot_valid;
         got.top        = rsp_ch.sprite_top;
         got.left       = rsp_ch.sprite_left;
         got.pattern    = rsp_ch.pattern_addr;
         got.palette    = rsp_ch.palette_number;
         got.in_front   = rsp_ch.in_front;
         got.mirror_x   = rsp_ch.mirror_x;
         got.mirror_y   = rsp_ch.mirror_y;
         got.overflow   = rsp_ch.overflow;
         got.entry0     = rsp_ch.entry0_on_line;
         got.last       = rsp_ch.last;
         if (expected_slots.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected slot word, expected none got slot %0d",
                     $time, got.slot_index);
         end else begin
            want = expected_slots.pop_front();
            check_field("slot_index", want.slot_index, got.slot_index);
            check_field("slot_valid", want.slot_valid, got.slot_valid);
            check_field("sprite_top", want.top, got.top);
            check_field("sprite_left", want.left, got.left);
            check_field("pattern_addr", want.pattern, got.pattern);
            check_field("palette_number", want.palette, got.palette);
            check_field("in_front", want.in_front, got.in_front);
            check_field("mirror_x", want.mirror_x, got.mirror_x);
            check_field("mirror_y", want.mirror_y, got.mirror_y);
            check_field("overflow", want.overflow, got.overflow);
            check_field("entry0_on_line", want.entry0, got.entry0);
            check_field("last", want.last, got.last);
         end
      end
   end

   // reset, directed table, then random scenes per mode setting
   initial begin : stimulus
      stim_row_t r;
      int        phase_end;
      int        pick;
      int        height;
      int        target;
      int        hits;
      int        entry;
      int        evals;
      req_ch.valid       <= 1'b0;
      req_ch.op          <= OP_WRITE;
      req_ch.attr_addr   <= '0;
      req_ch.attr_data   <= '0;
      req_ch.line_number <= '0;
      csr_ch.valid       <= 1'b0;
      csr_ch.index       <= CSR_TALL_SPRITES;
      csr_ch.data        <= '0;
      for (int a = 0; a < 256; a++) begin
         oam_copy[a] = '0;
      end
      tall_mode  = 1'b0;
      table_high = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed corner cases under reset modes
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         send_request(DIRECTED[i]);
      end
      req_ch.valid <= 1'b0;

      for (int p = 0; p < PHASES; p++) begin
         wait_idle();
         write_csr(CSR_TALL_SPRITES, PHASE_MODES[p][1]);
         write_csr(CSR_TABLE_HIGH, PHASE_MODES[p][0]);
         csr_ch.valid <= 1'b0;
         steady_pace = (p == 3);
         if (p == 1) begin
            hold_pending = 1'b1;
         end
         phase_end = sent_items + PHASE_ITEMS;
         while (sent_items < phase_end) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
               // scene: place sprites around a target line, then evaluate it
               height = tall_mode ? 16 : 8;
               target = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 239)
                                                   : $urandom_range(240, 255);
               hits   = $urandom_range(1, 10);
               for (int h = 0; h < hits; h++) begin
                  entry     = (h == 0 && $urandom_range(0, 3) == 0) ? 0
                                                                    : $urandom_range(0, 63);
                  r         = '0;
                  r.op      = OP_WRITE;
                  r.line_no = BYTE_W'($urandom);
                  r.addr    = ADDR_W'(entry * LANES + LANE_Y);
                  // one past the height lands just off the line
                  r.data    = BYTE_W'(target - $urandom_range(0, height) - 1);
                  send_request(r);
                  for (int lane = LANE_TILE; lane <= LANE_X; lane++) begin
                     if ($urandom_range(0, 1) == 1) begin
                        r.addr = ADDR_W'(entry * LANES + lane);
                        r.data = BYTE_W'($urandom);
                        send_request(r);
                     end
                  end
               end
               evals = $urandom_range(1, 3);
               for (int v = 0; v < evals; v++) begin
                  r         = '0;
                  r.op      = OP_EVAL;
                  r.addr    = ADDR_W'($urandom);
                  r.data    = BYTE_W'($urandom);
                  r.line_no = (v == 0) ? BYTE_W'(target)
                                       : BYTE_W'(target + $urandom_range(0, 4) - 2);
                  send_request(r);
               end
            end else begin
               // noise: stray byte write or evaluation of any line
               r         = '0;
               r.op      = (pick < 9) ? OP_WRITE : OP_EVAL;
               r.addr    = ADDR_W'($urandom);
               r.data    = BYTE_W'($urandom);
               r.line_no = BYTE_W'($urandom);
               send_request(r);
            end
         end
         req_ch.valid <= 1'b0;
      end

      // drain and report
      while (expected_slots.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/sle_pkg.sv
hw/rtl/sle_ifs.sv
hw/rtl/sle_ram.sv
hw/rtl/sle_hit_unit.sv
hw/rtl/sprite_line_evaluator_top.sv
verif/sprite_line_evaluator_top_test.sv
